>>> design/streaming_top_k_kth_largest_top_macros.svh
// Assertion macros for the streaming k-th largest selector.
`ifndef STREAMING_TOP_K_KTH_LARGEST_TOP_MACROS_SVH
`define STREAMING_TOP_K_KTH_LARGEST_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define STKK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STKK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define STKK_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define STKK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> design/stkk_pkg.sv
// Shared constants and types for the streaming k-th largest selector.
package stkk_pkg;

   localparam int DATA_W = 32;
   localparam int RANK_W = 5;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic              write_en;  // cells load their next value
      logic              replace;   // 1: drop smallest and insert, 0: plain insert
      logic [DATA_W-1:0] key;       // incoming sample, two's complement
   } stkk_ctrl_type;

endpackage

>>> design/stkk_cell.sv
// One cell of the sorted chain: holds one kept value, shifts with its neighbors.
module stkk_cell (
   input  logic                         clock,
   input  stkk_pkg::stkk_ctrl_type      ctrl,
   input  logic                         head,
   input  logic                         occupied,
   input  logic [stkk_pkg::DATA_W-1:0]  prev_value,
   input  logic                         prev_gt,
   input  logic [stkk_pkg::DATA_W-1:0]  next_value,
   input  logic                         next_lt,
   output logic [stkk_pkg::DATA_W-1:0]  value,
   output logic [stkk_pkg::DATA_W-1:0]  value_next,
   output logic                         gt,
   output logic                         lt
);
   import stkk_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   assign gt = occupied && ($signed(value_ff) > $signed(ctrl.key));
   assign lt = occupied && ($signed(value_ff) < $signed(ctrl.key));

   always_comb begin
      value_in = value_ff;
      if (ctrl.replace) begin
         // smallest leaves; smaller values slide toward the head
         if (next_lt) begin
            value_in = next_value;
         end else if (lt || head) begin
            value_in = ctrl.key;
         end
      end else begin
         // larger values slide away from the head; key lands at the gap
         if (prev_gt) begin
            value_in = prev_value;
         end else if (gt || !occupied) begin
            value_in = ctrl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write_en) begin
         value_ff <= value_in;
      end
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

>>> design/streaming_top_k_kth_largest_top.sv
// Top level of the streaming k-th largest selector: control, cell chain, result register.
`include "streaming_top_k_kth_largest_top_macros.svh"

// Usage
//   req: one beat per sample. tdata = sample_value (signed, 32 bits), tlast = end_of_set.
//   rsp: one beat per set, sent after the tlast beat. tdata = kth_largest (signed,
//        32 bits), tuser = set_shorter_than_k (set held fewer than k values; the
//        result is then the set minimum).
//   csr: write rank_k (5 bits). 0 acts as 1, values above MAX_RANK act as MAX_RANK.
//        A write drops any partial set. Write only while the block is idle.
// Throughput: one req beat per cycle while req_tready is high. Every cell of the chain
//   compares against the sample in parallel and shifts one place in the same cycle, so
//   no beat waits on another.
// Latency: the rsp beat is valid the cycle after the tlast beat is accepted.
// Stall: the result sits in the rsp register; req_tready drops only while that
//   register holds an untaken result and rsp_tready is low.
// Reset: rank_k returns to 1, the kept count to 0, no result pending. Kept values
//   need no clearing pass since only entries below the count are ever read.
module streaming_top_k_kth_largest_top #(
   parameter int MAX_RANK = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample beats
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [stkk_pkg::DATA_W-1:0]   req_tdata,   // [31:0] sample_value
   input  logic                          req_tlast,   // end_of_set
   // result beats
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [stkk_pkg::DATA_W-1:0]   rsp_tdata,   // [31:0] kth_largest
   output logic                          rsp_tuser,   // [0] set_shorter_than_k
   // rank register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [stkk_pkg::RANK_W-1:0]   csr_wdata    // [4:0] rank_k
);
   import stkk_pkg::*;

   localparam int CNT_W = $clog2(MAX_RANK + 1);
   localparam int EXT_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   // rank and fill state
   logic [CNT_W-1:0]  k_eff_ff,  k_eff_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic              rsp_short_ff, rsp_short_in;

   logic              req_accept;
   logic              csr_accept;
   logic              full;
   logic [CNT_W:0]    count_plus;
   stkk_ctrl_type     ctrl;

   // chain wiring
   logic [DATA_W-1:0] cell_value [MAX_RANK];
   logic [DATA_W-1:0] cell_next  [MAX_RANK];
   logic              cell_gt    [MAX_RANK];
   logic              cell_lt    [MAX_RANK];

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign full       = (count_ff >= k_eff_ff);
   assign count_plus = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};

   // Not full: plain sorted insert. Full: replace the head only if the
   // sample is not below it, otherwise the sample is dropped.
   always_comb begin
      ctrl.key      = req_tdata;
      ctrl.replace  = full;
      ctrl.write_en = req_accept &&
                      (!full || ($signed(req_tdata) >= $signed(cell_value[0])));
   end

   // effective rank, clamped to 1..MAX_RANK at write time
   always_comb begin
      k_eff_in = k_eff_ff;
      if (csr_accept) begin
         if (csr_wdata == '0) begin
            k_eff_in = CNT_W'(1);
         end else if (EXT_W'(csr_wdata) > EXT_W'(MAX_RANK)) begin
            k_eff_in = CNT_W'(MAX_RANK);
         end else begin
            k_eff_in = CNT_W'(csr_wdata);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (csr_accept) begin
         count_in = '0;
      end else if (req_accept) begin
         if (req_tlast) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_plus[CNT_W-1:0];
         end
      end
   end

   // result is the head after this beat's update
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_short_in = rsp_short_ff;
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ctrl.write_en ? cell_next[0] : cell_value[0];
         rsp_short_in = !full && (count_plus < {1'b0, k_eff_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_eff_ff     <= CNT_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_eff_ff     <= k_eff_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_short_ff;

   // Sorted chain, ascending from cell 0 (the smallest kept value).
   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      logic [DATA_W-1:0] prev_value;
      logic              prev_gt;
      logic [DATA_W-1:0] next_value;
      logic              next_lt;

      if (i == 0) begin : g_first
         assign prev_value = req_tdata;
         assign prev_gt    = 1'b0;
      end else begin : g_mid_prev
         assign prev_value = cell_value[i-1];
         assign prev_gt    = cell_gt[i-1];
      end

      if (i == MAX_RANK - 1) begin : g_last
         assign next_value = req_tdata;
         assign next_lt    = 1'b0;
      end else begin : g_mid_next
         assign next_value = cell_value[i+1];
         assign next_lt    = cell_lt[i+1];
      end

      stkk_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .head       (i == 0),
         .occupied   (CNT_W'(i) < count_ff),
         .prev_value (prev_value),
         .prev_gt    (prev_gt),
         .next_value (next_value),
         .next_lt    (next_lt),
         .value      (cell_value[i]),
         .value_next (cell_next[i]),
         .gt         (cell_gt[i]),
         .lt         (cell_lt[i])
      );
   end

   // ---- checks ----
   `STKK_ASSERT_NOW(a_count_within_rank, clock, reset, 1'b1, count_ff <= k_eff_ff, "kept count above rank")
   `STKK_ASSERT_NOW(a_rank_in_range, clock, reset, 1'b1, (k_eff_ff != '0) && (k_eff_ff <= CNT_W'(MAX_RANK)), "effective rank out of range")
   `STKK_ASSERT_NEXT(a_clear_after_last, clock, reset, req_accept && req_tlast, (count_ff == '0) && rsp_valid_ff, "set not closed after last beat")

endmodule
